>>> design/npi_pkg.sv
// ----------------------------------------------------------------------------
// npi_pkg: shared types and constants for the nearest palette index search
// Payload types of the item channels, register codes, controller states and
// the control groups that travel along the chain of search cells.
// ----------------------------------------------------------------------------
`default_nettype none

package npi_pkg;

    // Palette entries are interleaved over this many cells: entry k lives in
    // cell k % NUM_CELLS at bank address k / NUM_CELLS.
    localparam int NUM_CELLS  = 4;
    localparam int CELL_SEL_W = 2;

    localparam int IDX_W   = 10;
    localparam int COLOR_W = 8;
    localparam int MAXD_W  = 18;
    localparam int CNT_W   = 11;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [MAXD_W-1:0] MAX_DIST_RESET = 18'd195075;
    localparam logic [CNT_W-1:0]  ENTRIES_RESET  = 11'd1000;

    typedef enum logic [0:0] {
        FUNC_LOAD     = 1'b0,
        FUNC_CLASSIFY = 1'b1
    } t_func;

    typedef enum logic [0:0] {
        REG_MAX_DIST = 1'b0,
        REG_ENTRIES  = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_PUSH
    } t_state;

    typedef struct packed {
        t_func              func;
        logic [IDX_W-1:0]   entry_index;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0] match_index;
        logic             found;
    } t_rsp;

    // Control that walks down the chain with each bank address of a sweep.
    typedef struct packed {
        logic act;
        logic first;
        logic last;
    } t_sweep_ctl;

    // Control of the running best candidate handed from cell to cell.
    typedef struct packed {
        logic valid;
        logic hit;
    } t_tok_ctl;

endpackage

`default_nettype wire

>>> design/npi_if.sv
// ----------------------------------------------------------------------------
// npi_if: valid/ready channels of the nearest palette index search
// One interface for the request items and one for the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface npi_req_if import npi_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface npi_rsp_if import npi_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/npi_cell.sv
// ----------------------------------------------------------------------------
// npi_cell: one search cell of the palette chain
// Holds one bank of the palette, computes squared distances of its entries
// to the pixel, keeps the best of its bank and merges it into the running
// best that arrives from the previous cell.
// ----------------------------------------------------------------------------
`default_nettype none

module npi_cell import npi_pkg::*; #(
    parameter int PALETTE_DEPTH = 1024,
    parameter int CHANNEL_BITS  = 8,
    parameter int CELL_ID       = 0,
    localparam int CB         = CHANNEL_BITS,
    localparam int BANK_DEPTH = (PALETTE_DEPTH + NUM_CELLS - 1) / NUM_CELLS,
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1,
    localparam int KW         = $clog2(BANK_DEPTH * NUM_CELLS + 1),
    localparam int SUMW       = 2 * CHANNEL_BITS + 2,
    localparam int DW         = (SUMW > MAXD_W) ? SUMW : MAXD_W
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_wr_en,
    input  wire logic [BANK_AW-1:0]  i_wr_addr,
    input  wire logic [3*CB-1:0]     i_wr_color,
    input  wire logic [MAXD_W-1:0]   i_max_dist_sq,
    input  wire logic [KW-1:0]       i_count,
    input  wire t_sweep_ctl          i_sweep,
    input  wire logic [BANK_AW-1:0]  i_addr,
    input  wire logic [3*CB-1:0]     i_pix,
    output t_sweep_ctl               o_sweep,
    output logic [BANK_AW-1:0]       o_addr,
    output logic [3*CB-1:0]          o_pix,
    input  wire t_tok_ctl            i_tok,
    input  wire logic [DW-1:0]       i_tok_dist,
    input  wire logic [KW-1:0]       i_tok_idx,
    output t_tok_ctl                 o_tok,
    output logic [DW-1:0]            o_tok_dist,
    output logic [KW-1:0]            o_tok_idx
);

    logic [3*CB-1:0] mem [BANK_DEPTH];

    // Stage A: bank read, also the register handed to the next cell.
    t_sweep_ctl       r_sweep;
    logic [BANK_AW-1:0] r_addr;
    logic [3*CB-1:0]  r_pix;
    logic [3*CB-1:0]  r_rd;
    logic             r_en;
    logic [KW-1:0]    r_k;
    // Stage B: squared channel differences.
    t_sweep_ctl       r_b_sweep;
    logic             r_b_en;
    logic [KW-1:0]    r_b_k;
    logic [2*CB-1:0]  r_sq [3];
    // Stage C: best candidate of this bank.
    logic             r_c_last;
    logic             r_loc_hit;
    logic [DW-1:0]    r_loc_dist;
    logic [KW-1:0]    r_loc_k;
    // Stage D: merged candidate handed on.
    t_tok_ctl         r_tok;
    logic [DW-1:0]    r_tok_dist;
    logic [KW-1:0]    r_tok_k;

    logic [KW-1:0]    k_a;
    logic [CB-1:0]    diff [3];
    logic [CB-1:0]    ch_e;
    logic [CB-1:0]    ch_p;
    logic [DW-1:0]    sum;
    logic [DW-1:0]    base_dist;
    logic             base_hit;
    logic             take;
    logic             pick_loc;
    logic             n_loc_hit;
    logic [DW-1:0]    n_loc_dist;
    logic [KW-1:0]    n_loc_k;

    assign k_a = KW'({i_addr, CELL_SEL_W'(CELL_ID)});

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_color;
        end
        if (i_sweep.act) begin
            r_rd <= mem[i_addr];
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ch_e = r_rd[c*CB +: CB];
            ch_p = r_pix[c*CB +: CB];
            diff[c] = (ch_e >= ch_p) ? (ch_e - ch_p) : (ch_p - ch_e);
        end
    end

    always_comb begin
        sum       = DW'(r_sq[0]) + DW'(r_sq[1]) + DW'(r_sq[2]);
        base_dist = r_b_sweep.first ? DW'(i_max_dist_sq) : r_loc_dist;
        base_hit  = r_b_sweep.first ? 1'b0 : r_loc_hit;
        // Less-or-equal lets a later entry of equal distance take over.
        take       = r_b_en && (sum <= base_dist);
        n_loc_dist = take ? sum : base_dist;
        n_loc_hit  = take || base_hit;
        n_loc_k    = take ? r_b_k : r_loc_k;
    end

    // Banks interleave indexes, so ties between cells go to the higher index.
    assign pick_loc = r_loc_hit && (!i_tok.hit || (r_loc_dist < i_tok_dist) ||
                      ((r_loc_dist == i_tok_dist) && (r_loc_k > i_tok_idx)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep   <= '0;
            r_b_sweep <= '0;
            r_c_last  <= 1'b0;
            r_loc_hit <= 1'b0;
            r_tok     <= '0;
        end else begin
            r_sweep   <= i_sweep;
            r_b_sweep <= r_sweep;
            r_c_last  <= r_b_sweep.act && r_b_sweep.last;
            if (r_b_sweep.act) begin
                r_loc_hit <= n_loc_hit;
            end
            r_tok.valid <= r_c_last;
            if (r_c_last) begin
                r_tok.hit <= pick_loc ? 1'b1 : i_tok.hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= i_addr;
        r_pix  <= i_pix;
        r_en   <= k_a < i_count;
        r_k    <= k_a;
        r_b_en <= r_en;
        r_b_k  <= r_k;
        for (int c = 0; c < 3; c++) begin
            r_sq[c] <= (2*CB)'(diff[c]) * (2*CB)'(diff[c]);
        end
        if (r_b_sweep.act) begin
            r_loc_dist <= n_loc_dist;
            r_loc_k    <= n_loc_k;
        end
        if (r_c_last) begin
            r_tok_dist <= pick_loc ? r_loc_dist : i_tok_dist;
            r_tok_k    <= pick_loc ? r_loc_k : i_tok_idx;
        end
    end

    assign o_sweep    = r_sweep;
    assign o_addr     = r_addr;
    assign o_pix      = r_pix;
    assign o_tok      = r_tok;
    assign o_tok_dist = r_tok_dist;
    assign o_tok_idx  = r_tok_k;

endmodule

`default_nettype wire

>>> design/nearest_palette_index.sv
// ----------------------------------------------------------------------------
// nearest_palette_index: nearest palette color search
// Request items either load one palette entry (func load) or classify a
// pixel (func classify). A classify item returns one result item: the index
// of the palette entry at the least squared RGB distance within max_dist_sq,
// the highest index on ties, and a found flag (index 0 and found 0 if none).
// A load item returns nothing. The palette is spread over a chain of four
// cells, each owning one bank. A classify sweeps the banks one address per
// cycle, up to the last address that holds a used entry (at least one
// address), and then drains the chain. One request is worked on at a time.
// A finished result waits in the output register while the next request is
// taken; a stalled receiver holds the block only when a second result is
// ready behind it. Reset clears the controller and restores the registers
// (max_dist_sq 195075, entries_used 1000); the palette is undefined until
// loaded. The user is to write the registers over the APB port only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_index import npi_pkg::*; #(
    parameter int PALETTE_DEPTH = 1024,
    parameter int CHANNEL_BITS  = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    npi_req_if.sink                i_req,
    npi_rsp_if.source              o_rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int CB         = CHANNEL_BITS;
    localparam int BANK_DEPTH = (PALETTE_DEPTH + NUM_CELLS - 1) / NUM_CELLS;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int KW         = $clog2(BANK_DEPTH * NUM_CELLS + 1);
    localparam int SUMW       = 2 * CHANNEL_BITS + 2;
    localparam int DW         = (SUMW > MAXD_W) ? SUMW : MAXD_W;

    t_state             r_state;
    t_state             n_state;
    logic [MAXD_W-1:0]  r_max_dist;
    logic [CNT_W-1:0]   r_entries;
    logic [BANK_AW-1:0] r_addr;
    logic [BANK_AW-1:0] r_last_addr;
    logic [3*CB-1:0]    r_pix;
    t_rsp               r_hold;
    t_rsp               r_out;
    logic               r_out_valid;

    logic               req_fire;
    logic               classify_fire;
    logic               load_fire;
    logic               slot_ok;
    logic               out_load;
    logic               cfg_wr;
    t_reg               reg_sel;
    logic [KW-1:0]      cnt_sat;
    logic [KW-1:0]      cnt_m1;
    logic [BANK_AW-1:0] last_addr_calc;
    logic [3*CB-1:0]    in_color;
    logic [BANK_AW-1:0] wr_addr;
    logic [NUM_CELLS-1:0] wr_en;

    t_sweep_ctl         sweep_ctl [NUM_CELLS+1];
    logic [BANK_AW-1:0] sweep_addr [NUM_CELLS+1];
    logic [3*CB-1:0]    sweep_pix [NUM_CELLS+1];
    t_tok_ctl           tok_ctl [NUM_CELLS+1];
    logic [DW-1:0]      tok_dist [NUM_CELLS+1];
    logic [KW-1:0]      tok_idx [NUM_CELLS+1];

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_sel = t_reg'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_sel)
            REG_MAX_DIST: prdata = APB_DW'(r_max_dist);
            REG_ENTRIES:  prdata = APB_DW'(r_entries);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist <= MAX_DIST_RESET;
            r_entries  <= ENTRIES_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_MAX_DIST: r_max_dist <= pwdata[MAXD_W-1:0];
                REG_ENTRIES:  r_entries  <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    assign req_fire      = i_req.valid && i_req.ready;
    assign classify_fire = req_fire && (i_req.payload.func == FUNC_CLASSIFY);
    assign load_fire     = req_fire && (i_req.payload.func == FUNC_LOAD);
    assign slot_ok       = 32'(i_req.payload.entry_index) < 32'(PALETTE_DEPTH);
    assign in_color      = {CB'(i_req.payload.blue), CB'(i_req.payload.green),
                            CB'(i_req.payload.red)};
    assign wr_addr       = BANK_AW'(i_req.payload.entry_index >> CELL_SEL_W);

    always_comb begin
        cnt_sat = (32'(r_entries) > 32'(PALETTE_DEPTH)) ? KW'(PALETTE_DEPTH)
                                                       : KW'(r_entries);
        cnt_m1  = cnt_sat - KW'(1);
        // An empty search still runs one address with every entry masked off.
        last_addr_calc = (cnt_sat == '0) ? '0 : BANK_AW'(cnt_m1 >> CELL_SEL_W);
    end

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (classify_fire) n_state = ST_SWEEP;
            ST_SWEEP: if (r_addr == r_last_addr) n_state = ST_DRAIN;
            ST_DRAIN: if (tok_ctl[NUM_CELLS].valid) n_state = ST_PUSH;
            ST_PUSH:  if (out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready        = (r_state == ST_IDLE);
        out_load           = (r_state == ST_PUSH) && (!r_out_valid || o_rsp.ready);
        sweep_ctl[0].act   = (r_state == ST_SWEEP);
        sweep_ctl[0].first = (r_addr == '0);
        sweep_ctl[0].last  = (r_addr == r_last_addr);
        sweep_addr[0]      = r_addr;
        sweep_pix[0]       = r_pix;
        tok_ctl[0]         = '0;
        tok_dist[0]        = '0;
        tok_idx[0]         = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (classify_fire) begin
            r_pix       <= in_color;
            r_last_addr <= last_addr_calc;
            r_addr      <= '0;
        end else if (r_state == ST_SWEEP) begin
            r_addr <= r_addr + BANK_AW'(1);
        end
        if ((r_state == ST_DRAIN) && tok_ctl[NUM_CELLS].valid) begin
            r_hold.match_index <= tok_ctl[NUM_CELLS].hit ? IDX_W'(tok_idx[NUM_CELLS])
                                                         : '0;
            r_hold.found       <= tok_ctl[NUM_CELLS].hit;
        end
        if (out_load) begin
            r_out <= r_hold;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
        assign wr_en[j] = load_fire && slot_ok &&
                          (i_req.payload.entry_index[CELL_SEL_W-1:0] == CELL_SEL_W'(j));

        npi_cell #(
            .PALETTE_DEPTH (PALETTE_DEPTH),
            .CHANNEL_BITS  (CHANNEL_BITS),
            .CELL_ID       (j)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_wr_en       (wr_en[j]),
            .i_wr_addr     (wr_addr),
            .i_wr_color    (in_color),
            .i_max_dist_sq (r_max_dist),
            .i_count       (cnt_sat),
            .i_sweep       (sweep_ctl[j]),
            .i_addr        (sweep_addr[j]),
            .i_pix         (sweep_pix[j]),
            .o_sweep       (sweep_ctl[j+1]),
            .o_addr        (sweep_addr[j+1]),
            .o_pix         (sweep_pix[j+1]),
            .i_tok         (tok_ctl[j]),
            .i_tok_dist    (tok_dist[j]),
            .i_tok_idx     (tok_idx[j]),
            .o_tok         (tok_ctl[j+1]),
            .o_tok_dist    (tok_dist[j+1]),
            .o_tok_idx     (tok_idx[j+1])
        );
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_tok_only_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_ctl[NUM_CELLS].valid |-> (r_state == ST_DRAIN))
        else $error("search result left the chain outside the drain phase");

    a_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (r_addr <= r_last_addr))
        else $error("sweep address ran past the last bank address");

    a_classify_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        classify_fire |=> ((r_state == ST_SWEEP) && (r_addr == '0)))
        else $error("classify item did not start a sweep at address zero");

    a_push_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_PUSH) && r_out_valid && !o_rsp.ready) |=> (r_state == ST_PUSH))
        else $error("pending result dropped while the output was stalled");

endmodule

`default_nettype wire
